[design/qsl_pkg.sv]
// Shared types and constants for the quicksort sorter: beat payloads,
// controller states, and the command/status structs between control and datapath.
// No dependencies.
`timescale 1ns / 1ps

package qsl_pkg;

    localparam int QSL_DEPTH = 64;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PIV_RD,
        S_PIV_LD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SCAN_SWP,
        S_FIN_RD,
        S_FIN_WHI,
        S_FIN_WST,
        S_PUSH_R,
        S_POP_RD,
        S_POP_LD,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // Write port source and address selection.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_ST_K,
        WR_K_S,
        WR_HI_S,
        WR_ST_PIV
    } t_wr_sel;

    // Read port address selection.
    typedef enum logic [2:0] {
        RD_NONE,
        RD_PIV,
        RD_SCAN,
        RD_FIN,
        RD_EMIT
    } t_rd_sel;

    typedef struct packed {
        t_wr_sel wr_sel;
        t_rd_sel rd_sel;
        logic    piv_ld;
        logic    st_inc;
        logic    k_inc;
        logic    push_l;
        logic    push_r;
        logic    pop_rd;
        logic    pop_ld;
        logic    emit_ld;
    } t_cmd;

    typedef struct packed {
        logic in_close;
        logic in_single;
        logic less;
        logic k_last;
        logic sp_zero;
        logic e_last;
        logic out_free;
    } t_status;

endpackage

[design/qsl_ctrl.sv]
// Sequencer for the sorter: load, Lomuto partition passes, range stack pops, emit.
// Drives qsl_pkg::t_cmd to the datapath and reads qsl_pkg::t_status back.
// Depends on qsl_pkg.
`timescale 1ns / 1ps

module qsl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  qsl_pkg::t_status i_status,
    output logic             o_in_ready,
    output qsl_pkg::t_cmd    o_cmd
);
    import qsl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_status.in_close) begin
                    n_state = i_status.in_single ? S_EMIT_RD : S_PIV_RD;
                end
            end
            S_PIV_RD:   n_state = S_PIV_LD;
            S_PIV_LD:   n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_status.less) begin
                    n_state = S_SCAN_SWP;
                end else begin
                    n_state = i_status.k_last ? S_FIN_RD : S_SCAN_RD;
                end
            end
            S_SCAN_SWP: n_state = i_status.k_last ? S_FIN_RD : S_SCAN_RD;
            S_FIN_RD:   n_state = S_FIN_WHI;
            S_FIN_WHI:  n_state = S_FIN_WST;
            S_FIN_WST:  n_state = S_PUSH_R;
            S_PUSH_R:   n_state = S_POP_RD;
            S_POP_RD:   n_state = i_status.sp_zero ? S_EMIT_RD : S_POP_LD;
            S_POP_LD:   n_state = S_PIV_RD;
            S_EMIT_RD:  n_state = S_EMIT_LD;
            S_EMIT_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.e_last ? S_LOAD : S_EMIT_RD;
                end
            end
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_sel = WR_LOAD;
                end
            end
            S_PIV_RD: o_cmd.rd_sel = RD_PIV;
            S_PIV_LD: o_cmd.piv_ld = 1'b1;
            S_SCAN_RD: o_cmd.rd_sel = RD_SCAN;
            S_SCAN_CMP: begin
                if (i_status.less) begin
                    // First half of the exchange; the index moves on in the next cycle.
                    o_cmd.wr_sel = WR_ST_K;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_SCAN_SWP: begin
                o_cmd.wr_sel = WR_K_S;
                o_cmd.st_inc = 1'b1;
                o_cmd.k_inc  = 1'b1;
            end
            S_FIN_RD:  o_cmd.rd_sel = RD_FIN;
            S_FIN_WHI: o_cmd.wr_sel = WR_HI_S;
            S_FIN_WST: begin
                o_cmd.wr_sel = WR_ST_PIV;
                o_cmd.push_l = 1'b1;
            end
            S_PUSH_R: o_cmd.push_r = 1'b1;
            S_POP_RD: begin
                if (!i_status.sp_zero) begin
                    o_cmd.pop_rd = 1'b1;
                end
            end
            S_POP_LD:  o_cmd.pop_ld = 1'b1;
            S_EMIT_RD: o_cmd.rd_sel = RD_EMIT;
            S_EMIT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_ld = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[design/qsl_datapath.sv]
// Datapath for the sorter: value memory (two reads, one write), range stack memory,
// partition indices, pivot and the output register.
// Depends on qsl_pkg.
`timescale 1ns / 1ps

module qsl_datapath #(
    parameter int DEPTH = qsl_pkg::QSL_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qsl_pkg::t_cmd      i_cmd,
    input  qsl_pkg::t_in_beat  i_in_data,
    input  logic               i_out_ready,
    output qsl_pkg::t_status   o_status,
    output logic               o_out_valid,
    output qsl_pkg::t_out_beat o_out_data
);
    import qsl_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SP_W  = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]  r_mem [DEPTH];
    logic [2*IDX_W-1:0] r_stack [DEPTH];

    logic [IDX_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_lo;
    logic [IDX_W-1:0]         r_hi;
    logic [IDX_W-1:0]         r_k;
    logic [IDX_W-1:0]         r_st;
    logic [IDX_W-1:0]         r_e;
    logic [IDX_W-1:0]         r_last;
    logic [SP_W-1:0]          r_sp;
    logic signed [DATA_W-1:0] r_pivot;
    logic signed [DATA_W-1:0] r_rd_a;
    logic signed [DATA_W-1:0] r_rd_b;
    logic [2*IDX_W-1:0]       r_stk_rd;
    logic                     r_out_valid;
    t_out_beat                r_out;
    logic                     n_out_valid;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en_a;
    logic                     rd_en_b;
    logic [IDX_W-1:0]         rd_addr_a;
    logic [IDX_W-1:0]         rd_addr_b;

    logic                     load;
    logic                     in_close;
    logic                     push_l_ok;
    logic                     push_r_ok;
    logic                     push_en;
    logic [2*IDX_W-1:0]       push_entry;
    logic                     stack_room;
    logic [SP_W-1:0]          sp_m1;

    assign load     = (i_cmd.wr_sel == WR_LOAD);
    // A full store closes the set just as a marked last beat does.
    assign in_close = i_in_data.last_item || (r_count == IDX_W'(DEPTH - 1));

    // Left range (lo, st-1) only when it holds two or more entries; same for the right.
    assign push_l_ok  = {1'b0, r_st} > ({1'b0, r_lo} + 1'b1);
    assign push_r_ok  = {1'b0, r_hi} > ({1'b0, r_st} + 1'b1);
    assign stack_room = r_sp < SP_W'(DEPTH);
    assign push_en    = stack_room &&
                        ((i_cmd.push_l && push_l_ok) || (i_cmd.push_r && push_r_ok));
    assign push_entry = i_cmd.push_l ? {r_lo, r_st - 1'b1} : {r_st + 1'b1, r_hi};
    assign sp_m1      = r_sp - 1'b1;

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_st;
        wr_data = r_rd_a;
        case (i_cmd.wr_sel)
            WR_LOAD: begin
                wr_addr = r_count;
                wr_data = i_in_data.value;
            end
            WR_ST_K: begin
                wr_addr = r_st;
                wr_data = r_rd_a;
            end
            WR_K_S: begin
                wr_addr = r_k;
                wr_data = r_rd_b;
            end
            WR_HI_S: begin
                wr_addr = r_hi;
                wr_data = r_rd_b;
            end
            WR_ST_PIV: begin
                wr_addr = r_st;
                wr_data = r_pivot;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_en_a   = 1'b0;
        rd_en_b   = 1'b0;
        rd_addr_a = r_k;
        rd_addr_b = r_st;
        case (i_cmd.rd_sel)
            RD_PIV: begin
                rd_en_a   = 1'b1;
                rd_addr_a = r_hi;
            end
            RD_SCAN: begin
                rd_en_a = 1'b1;
                rd_en_b = 1'b1;
            end
            RD_FIN: begin
                rd_en_b = 1'b1;
            end
            RD_EMIT: begin
                rd_en_a   = 1'b1;
                rd_addr_a = r_e;
            end
            default: begin
                rd_en_a = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            r_rd_a <= r_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_sp[IDX_W-1:0]] <= push_entry;
        end
        if (i_cmd.pop_rd) begin
            r_stk_rd <= r_stack[sp_m1[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sp    <= '0;
        end else begin
            if (load) begin
                r_count <= in_close ? '0 : r_count + 1'b1;
            end
            if (push_en) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd.pop_rd) begin
                r_sp <= sp_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && in_close) begin
            r_lo   <= '0;
            r_hi   <= r_count;
            r_last <= r_count;
            r_e    <= '0;
        end
        if (i_cmd.pop_ld) begin
            {r_lo, r_hi} <= r_stk_rd;
        end
        if (i_cmd.piv_ld) begin
            r_pivot <= r_rd_a;
            r_k     <= r_lo;
            r_st    <= r_lo;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.st_inc) begin
                r_st <= r_st + 1'b1;
            end
        end
        if (i_cmd.emit_ld) begin
            r_e                <= r_e + 1'b1;
            r_out.sorted_value <= r_rd_a;
            r_out.last_out     <= (r_e == r_last);
        end
    end

    always_comb begin
        if (i_cmd.emit_ld) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_status.in_close  = in_close;
    assign o_status.in_single = (r_count == '0);
    assign o_status.less      = (r_rd_a < r_pivot);
    assign o_status.k_last    = (({1'b0, r_k} + 1'b1) == {1'b0, r_hi});
    assign o_status.sp_zero   = (r_sp == '0);
    assign o_status.e_last    = (r_e == r_last);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The store index never runs ahead of the scan index within a partition.
    a_st_behind_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_sel == WR_ST_K) |-> (r_st <= r_k))
        else $error("partition store index passed scan index");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_sel == RD_SCAN) |-> (r_k < r_hi))
        else $error("scan read beyond the pivot position");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop_rd |-> (r_sp != '0))
        else $error("range stack popped while empty");

    a_no_out_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_ld |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before its beat was taken");
`endif

endmodule

[design/quicksort_lomuto_sorter.sv]
// Quicksort sorter, Lomuto partition, explicit range stack; top level over qsl_ctrl and qsl_datapath.
// Loading takes one beat per cycle. Each partition of a range loads its pivot, then reads and
// compares each scanned entry (read, compare, optional exchange over two writes on the single
// write port), then does the final exchange and stack handling. Already sorted input is the
// worst case for this partition.
// Results are read from memory, then loaded into the output register; the next set loads while
// the final result waits. Synchronous active-low reset clears control state; no clearing pass.
`timescale 1ns / 1ps

module quicksort_lomuto_sorter #(
    parameter int DEPTH = qsl_pkg::QSL_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  qsl_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output qsl_pkg::t_out_beat o_out_data
);
    import qsl_pkg::*;

    t_cmd    cmd;
    t_status status;

    qsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    qsl_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[bench/tb_quicksort_lomuto_sorter.sv]
// Self-checking testbench for quicksort_lomuto_sorter: sends sets of signed values and
// checks every sorted beat against an in-bench Lomuto quicksort predictor.
// Depends on qsl_pkg and the quicksort_lomuto_sorter RTL.
`timescale 1ns / 1ps

module tb_quicksort_lomuto_sorter;
    import qsl_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int QUIET_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_beat   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_beat  out_data;

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int quiet_cycles;

    // Values of the set being loaded, and sorted beats still owed by the block.
    logic signed [DATA_W-1:0] loading_set[$];
    t_out_beat                pending_sorted[$];

    quicksort_lomuto_sorter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Adds one accepted value to the set; once the set closes, sorts it with the
    // Lomuto scheme on an explicit range stack and queues the sorted beats.
    task automatic absorb_value(input t_in_beat beat);
        logic signed [DATA_W-1:0] vals[QSL_DEPTH];
        logic signed [DATA_W-1:0] pivot;
        logic signed [DATA_W-1:0] tmp;
        int        range_lo[$];
        int        range_hi[$];
        int        n;
        int        lo;
        int        hi;
        int        st;
        t_out_beat ob;
        loading_set.push_back(beat.value);
        if (!beat.last_item && loading_set.size() < QSL_DEPTH) return;
        n = loading_set.size();
        foreach (loading_set[i]) vals[i] = loading_set[i];
        if (n > 1) begin
            range_lo.push_back(0);
            range_hi.push_back(n - 1);
        end
        while (range_lo.size() > 0) begin
            lo = range_lo.pop_back();
            hi = range_hi.pop_back();
            pivot = vals[hi];
            st = lo;
            for (int k = lo; k < hi; k++) begin
                if (vals[k] < pivot) begin
                    tmp = vals[st];
                    vals[st] = vals[k];
                    vals[k] = tmp;
                    st++;
                end
            end
            tmp = vals[st];
            vals[st] = vals[hi];
            vals[hi] = tmp;
            if (st - 1 > lo) begin
                range_lo.push_back(lo);
                range_hi.push_back(st - 1);
            end
            if (hi > st + 1) begin
                range_lo.push_back(st + 1);
                range_hi.push_back(hi);
            end
        end
        for (int k = 0; k < n; k++) begin
            ob.sorted_value = vals[k];
            ob.last_out = (k == n - 1);
            pending_sorted.push_back(ob);
        end
        loading_set.delete();
    endtask

    // Presents one beat after a random gap and holds it until the block takes it.
    task automatic push_value(input logic signed [DATA_W-1:0] v, input logic lst);
        t_in_beat beat;
        beat.value = v;
        beat.last_item = lst;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        in_data = beat;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        absorb_value(beat);
    endtask

    // Mixes extremes and a narrow band around zero so duplicates are common.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return {1'b0, {(DATA_W-1){1'b1}}};
            1: return {1'b1, {(DATA_W-1){1'b0}}};
            2, 3: return $signed(DATA_W'($urandom_range(15))) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_sets();
        logic signed [DATA_W-1:0] max_v;
        logic signed [DATA_W-1:0] min_v;
        max_v = {1'b0, {(DATA_W-1){1'b1}}};
        min_v = {1'b1, {(DATA_W-1){1'b0}}};
        // A set of one element.
        push_value(max_v, 1'b1);
        // Both extremes, zero and the values next to it, with repeats.
        push_value(max_v, 1'b0);
        push_value(min_v, 1'b0);
        push_value(0, 1'b0);
        push_value(-1, 1'b0);
        push_value(1, 1'b0);
        push_value(min_v, 1'b0);
        push_value(max_v, 1'b1);
        // All values equal.
        repeat (3) push_value(-5, 1'b0);
        push_value(-5, 1'b1);
        // A descending pair.
        push_value(100, 1'b0);
        push_value(-100, 1'b1);
    endtask

    task automatic test_random_sets(input int count);
        int sent;
        int len;
        sent = 0;
        while (sent < count) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) push_value(pick_value(), k == len - 1);
            sent += len;
        end
    endtask

    // Ascending data is the slowest case for this partition; the set is never
    // flagged, so it must close when the store fills.
    task automatic test_full_ascending();
        logic signed [DATA_W-1:0] v;
        v = {1'b1, {(DATA_W-1){1'b0}}} + $urandom_range(1000);
        for (int k = 0; k < QSL_DEPTH; k++) begin
            push_value(v, 1'b0);
            v = v + $urandom_range(1 << 20);
        end
    endtask

    task automatic test_full_flagged();
        for (int k = 0; k < QSL_DEPTH; k++) push_value(pick_value(), k == QSL_DEPTH - 1);
    endtask

    always @(negedge i_clk) begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_sorted
        t_out_beat want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_sorted.size() == 0) begin
                report_mismatch("beat with nothing pending", out_data.sorted_value, '0);
            end else begin
                want = pending_sorted.pop_front();
                if (out_data.sorted_value !== want.sorted_value)
                    report_mismatch("sorted_value", out_data.sorted_value, want.sorted_value);
                if (out_data.last_out !== want.last_out)
                    report_mismatch("last_out", DATA_W'(out_data.last_out),
                                    DATA_W'(want.last_out));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no beat moved in %0d cycles", $time, QUIET_LIMIT);
                $display("quicksort_lomuto_sorter regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_sets();
        test_random_sets(12);

        send_idle_pct = 67;
        test_full_ascending();
        test_random_sets(12);

        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_full_flagged();
        test_random_sets(12);

        send_idle_pct = 20;
        recv_stall_pct = 20;
        test_random_sets(12);

        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("quicksort_lomuto_sorter regression: pass");
        end else begin
            $display("quicksort_lomuto_sorter regression: fail");
        end
        $finish;
    end

endmodule
